// ----- sv/glos_pkg.sv -----
// ----------------------------------------------------------------------------
// glos_pkg: shared types and constants for the grid line-of-sight check
// Field widths, item codes and configuration register indexes.
// ----------------------------------------------------------------------------
package glos_pkg;

  // Coordinate and configuration widths
  localparam int CoordW = 16;
  localparam int CfgW   = 17;
  localparam int NbW    = 4;

  // Exact index y * row_width + x fits in 33 bits
  localparam int IdxW   = 33;

  // Bresenham error term, signed, holds about +/- 2 * 65535
  localparam int ErrW   = 19;

  // Stream payload widths
  localparam int InDataW  = 72;
  localparam int OutDataW = 8;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_ROW_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_GRID_CELLS = 1'b1;

  // Item kinds carried on tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register reset values
  localparam logic [CfgW-1:0] ROW_WIDTH_RST  = 17'd256;
  localparam logic [CfgW-1:0] GRID_CELLS_RST = 17'd65536;

  typedef logic [CoordW-1:0]      coord_t;
  typedef logic [IdxW-1:0]        idx_t;
  typedef logic signed [ErrW-1:0] err_t;

endpackage

// ----- sv/grid_line_of_sight_check_top.sv -----
// A result is loaded for every write beat and every query. A query with an endpoint out of range
// ends without a walk; a walked query reads max(|dx|,|dy|) + 1 cells, fewer when a blocked or
// out-of-range cell ends the walk, one map bit per cycle. One item is in work at a time; the
// next beat is taken the cycle after a result is loaded, and the output register holds that
// result while the next item runs. Reset (sync) sets row_width 256, grid_cells 65536 and
// sweeps every map address open.
// ----------------------------------------------------------------------------
// grid_line_of_sight_check_top
// Keeps a one-bit blocked map of an occupancy grid and checks Bresenham lines
// against it, one cell per cycle through a synchronous memory.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check_top #(
  parameter int GRID_DEPTH = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48],
  // cell_unpassable[64], cell_neighbors[68:65], zero fill [71:69]
  input  logic [glos_pkg::InDataW-1:0]    s_tdata,
  // cmd[0]
  input  logic                            s_tuser,
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // clear[0], out_of_range[1], zero fill [7:2]
  output logic [glos_pkg::OutDataW-1:0]   m_tdata,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [glos_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [glos_pkg::CfgW-1:0]       cfg_data
);

  localparam int AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
  localparam logic [glos_pkg::IdxW-1:0] DEPTH_IDX = glos_pkg::IdxW'(GRID_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_S,
    ST_ADD_S,
    ST_ADD_E,
    ST_CHECK,
    ST_WALK,
    ST_WRITE,
    ST_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic [glos_pkg::CfgW-1:0] row_width;
  logic [glos_pkg::CfgW-1:0] grid_cells;

  // Item registers
  logic               cmd;
  glos_pkg::coord_t   x_start, y_start, x_end, y_end;
  logic               wr_blocked;
  glos_pkg::coord_t   dx, dy;
  logic               x_neg, y_neg;

  // Index arithmetic
  glos_pkg::idx_t     prod;
  glos_pkg::idx_t     idx_s, idx_e;
  glos_pkg::idx_t     bound;

  // Walk state
  glos_pkg::idx_t     cur_idx;
  glos_pkg::idx_t     step_major, step_minor;
  glos_pkg::err_t     err, inc1, inc2;
  glos_pkg::coord_t   remaining;
  logic               issuing;
  logic               p_valid, p_oob, p_last;

  // Result
  logic               res_clear, res_oor;

  // Map memory and clearing pass
  logic               blocked_mem [GRID_DEPTH];
  logic               rd_bit;
  logic               clr_active;
  logic [AW-1:0]      clr_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               mem_wdata;

  // Setup values for the walk
  logic               major_x;
  glos_pkg::coord_t   dmaj, dmin;
  glos_pkg::err_t     dmaj_s, dmin_s;
  glos_pkg::idx_t     row_pos, row_neg, one_pos, one_neg;
  glos_pkg::idx_t     mul_y;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && !clr_active;

  // Bound is the smaller of grid_cells and the map depth
  always_comb begin
    bound = glos_pkg::IdxW'(grid_cells);
    if (bound > DEPTH_IDX) begin
      bound = DEPTH_IDX;
    end
  end

  // Pick walk direction and step deltas
  always_comb begin
    major_x = dx > dy;
    dmaj    = major_x ? dx : dy;
    dmin    = major_x ? dy : dx;
    dmaj_s  = glos_pkg::ErrW'(dmaj);
    dmin_s  = glos_pkg::ErrW'(dmin);
    row_pos = glos_pkg::IdxW'(row_width);
    row_neg = glos_pkg::IdxW'(0) - row_pos;
    one_pos = glos_pkg::IdxW'(1);
    one_neg = glos_pkg::IdxW'(0) - one_pos;
    mul_y   = glos_pkg::IdxW'((state == ST_MUL_S) ? y_start : y_end);
  end

  // Memory write port: clearing pass or cell write
  always_comb begin
    mem_we    = clr_active || ((state == ST_WRITE) && (idx_s < bound));
    mem_waddr = clr_active ? clr_addr : idx_s[AW-1:0];
    mem_wdata = clr_active ? 1'b0 : wr_blocked;
  end

  // Blocked map, one read per cycle with registered data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      blocked_mem[mem_waddr] <= mem_wdata;
    end
    rd_bit <= blocked_mem[cur_idx[AW-1:0]];
  end

  // Control, walk and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      row_width  <= glos_pkg::ROW_WIDTH_RST;
      grid_cells <= glos_pkg::GRID_CELLS_RST;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      issuing    <= 1'b0;
      p_valid    <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
    end else begin
      // Configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          glos_pkg::REG_ROW_WIDTH:  row_width  <= cfg_data;
          glos_pkg::REG_GRID_CELLS: grid_cells <= cfg_data;
          default: ;
        endcase
      end

      // Sweep the map to open after reset
      if (clr_active) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          clr_active <= 1'b0;
        end
      end

      // Load a finished result, drop it once taken
      if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            cmd        <= s_tuser;
            x_start    <= s_tdata[15:0];
            y_start    <= s_tdata[31:16];
            x_end      <= s_tdata[47:32];
            y_end      <= s_tdata[63:48];
            wr_blocked <= s_tdata[64] || (s_tdata[68:65] != '0);
            x_neg      <= s_tdata[47:32] < s_tdata[15:0];
            y_neg      <= s_tdata[63:48] < s_tdata[31:16];
            dx <= (s_tdata[47:32] >= s_tdata[15:0]) ? s_tdata[47:32] - s_tdata[15:0]
                                                     : s_tdata[15:0] - s_tdata[47:32];
            dy <= (s_tdata[63:48] >= s_tdata[31:16]) ? s_tdata[63:48] - s_tdata[31:16]
                                                      : s_tdata[31:16] - s_tdata[63:48];
            state <= ST_MUL_S;
          end
        end

        ST_MUL_S: begin
          prod  <= mul_y * row_pos;
          state <= ST_ADD_S;
        end

        ST_ADD_S: begin
          idx_s <= prod + glos_pkg::IdxW'(x_start);
          prod  <= mul_y * row_pos;
          state <= (cmd == glos_pkg::CMD_WRITE) ? ST_WRITE : ST_ADD_E;
        end

        ST_ADD_E: begin
          idx_e <= prod + glos_pkg::IdxW'(x_end);
          state <= ST_CHECK;
        end

        ST_CHECK: begin
          if ((idx_s >= bound) || (idx_e >= bound)) begin
            res_clear <= 1'b0;
            res_oor   <= 1'b1;
            state     <= ST_FIN;
          end else begin
            res_oor    <= 1'b0;
            cur_idx    <= idx_s;
            err        <= (dmin_s <<< 1) - dmaj_s;
            inc1       <= (dmin_s - dmaj_s) <<< 1;
            inc2       <= dmin_s <<< 1;
            remaining  <= dmaj;
            step_major <= major_x ? (x_neg ? one_neg : one_pos)
                                  : (y_neg ? row_neg : row_pos);
            step_minor <= major_x ? (y_neg ? row_neg : row_pos)
                                  : (x_neg ? one_neg : one_pos);
            issuing    <= 1'b1;
            state      <= ST_WALK;
          end
        end

        ST_WALK: begin
          p_oob  <= cur_idx >= bound;
          p_last <= remaining == '0;
          // Check the cell read last cycle
          if (p_valid && (p_oob || rd_bit)) begin
            res_clear <= 1'b0;
            issuing   <= 1'b0;
            p_valid   <= 1'b0;
            state     <= ST_FIN;
          end else if (p_valid && p_last) begin
            res_clear <= 1'b1;
            p_valid   <= 1'b0;
            state     <= ST_FIN;
          end else begin
            // Issue the current cell and advance along the line
            p_valid <= issuing;
            if (issuing) begin
              if (remaining == '0) begin
                issuing <= 1'b0;
              end else begin
                remaining <= remaining - glos_pkg::CoordW'(1);
                if (!err[glos_pkg::ErrW-1]) begin
                  err     <= err + inc1;
                  cur_idx <= cur_idx + step_major + step_minor;
                end else begin
                  err     <= err + inc2;
                  cur_idx <= cur_idx + step_major;
                end
              end
            end
          end
        end

        ST_WRITE: begin
          res_clear <= 1'b0;
          res_oor   <= idx_s >= bound;
          state     <= ST_FIN;
        end

        ST_FIN: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {6'b0, res_oor, res_clear};
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
